/* src/sfmf_pkg.sv */
// Package: shared constants, types and helpers of the substring first-match finder.
package sfmf_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int MAX_SOURCE  = 65536;
    localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int CNT_W       = $clog2(MAX_SOURCE + 1);
    localparam int POS_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_INSENS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 3'd4;

    typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_t;

    typedef struct packed {
        window_t            pattern;
        logic [LEN_W-1:0]   active_len;   // already clamped to MAX_PATTERN
        logic               case_insens;
        logic [POS_W-1:0]   start_offset;
    } cfg_t;

    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c,
                                               input logic ci);
        logic [BYTE_W-1:0] r;
        r = c;
        if (ci && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

/* src/sfmf_cfg_regs.sv */
// Configuration register file of the substring first-match finder.
module sfmf_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfmf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sfmf_pkg::cfg_t                   cfg
);

    logic [sfmf_pkg::CFG_DATA_W-1:0] pat_low_reg;
    logic [sfmf_pkg::CFG_DATA_W-1:0] pat_high_reg;
    logic [sfmf_pkg::LEN_W-1:0]      pat_len_reg;
    logic                            case_insens_reg;
    logic [sfmf_pkg::POS_W-1:0]      start_offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg      <= '0;
            pat_high_reg     <= '0;
            pat_len_reg      <= '0;
            case_insens_reg  <= 1'b1;
            start_offset_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                sfmf_pkg::REG_PATTERN_LOW:  pat_low_reg      <= cfg_data;
                sfmf_pkg::REG_PATTERN_HIGH: pat_high_reg     <= cfg_data;
                sfmf_pkg::REG_PATTERN_LEN:  pat_len_reg      <= cfg_data[sfmf_pkg::LEN_W-1:0];
                sfmf_pkg::REG_CASE_INSENS:  case_insens_reg  <= cfg_data[0];
                sfmf_pkg::REG_START_OFFSET: start_offset_reg <= cfg_data[sfmf_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.pattern      = {pat_high_reg, pat_low_reg};
        cfg.case_insens  = case_insens_reg;
        cfg.start_offset = start_offset_reg;
        if (pat_len_reg > sfmf_pkg::LEN_W'(sfmf_pkg::MAX_PATTERN)) begin
            cfg.active_len = sfmf_pkg::LEN_W'(sfmf_pkg::MAX_PATTERN);
        end else begin
            cfg.active_len = pat_len_reg;
        end
    end

endmodule

/* src/sfmf_match.sv */
// Parallel window-against-pattern compare with optional A-Z case folding.
module sfmf_match (
    input  sfmf_pkg::window_t  window,   // newest byte at the top index
    input  sfmf_pkg::cfg_t     cfg,
    output logic               equal
);

    logic [sfmf_pkg::MAX_PATTERN-1:0] lane_ok;

    for (genvar j = 0; j < sfmf_pkg::MAX_PATTERN; j++) begin : g_lane
        logic [sfmf_pkg::LEN_W-1:0]  sel;
        logic [sfmf_pkg::BYTE_W-1:0] w_byte;
        always_comb begin
            // lane j lines up with window slot MAX_PATTERN - len + j
            sel     = sfmf_pkg::LEN_W'(sfmf_pkg::MAX_PATTERN + j) - cfg.active_len;
            w_byte  = window[sel[sfmf_pkg::PAT_IDX_W-1:0]];
            lane_ok[j] = (sfmf_pkg::LEN_W'(j) >= cfg.active_len) ||
                         (sfmf_pkg::fold(w_byte, cfg.case_insens) ==
                          sfmf_pkg::fold(cfg.pattern[j], cfg.case_insens));
        end
    end

    assign equal = &lane_ok;

endmodule

/* src/substring_first_match_finder_unit.sv */
// A last item's result passes the input register, then the result register, to m_tvalid.
// Throughput: one item per cycle; the input register drains whenever the
//   result register is free or being taken, and items without tlast never wait.
// Reset (aresetn low, synchronous): clears the count, the match record, valid
//   flags and configuration (case_insensitive to 1, all else to 0).
module substring_first_match_finder_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // source channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] source_byte
    input  logic                             s_tlast,   // last_byte
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // [15:0] position
    output logic                             m_tuser,   // [0] found
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    sfmf_pkg::cfg_t cfg;

    sfmf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register: one item held until the compare stage takes it
    logic                          in_valid_reg;
    logic [sfmf_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                          in_last_reg;

    // Per-source state
    sfmf_pkg::window_t             win_reg;
    logic [sfmf_pkg::CNT_W-1:0]    seen_reg;
    logic                          match_seen_reg;
    logic [sfmf_pkg::POS_W-1:0]    match_start_reg;

    // Result register
    logic                          out_valid_reg;
    logic                          out_found_reg;
    logic [sfmf_pkg::POS_W-1:0]    out_pos_reg;

    logic out_free;
    logic advance;

    // Only a last item needs room in the result register
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Compare stage: shift the new byte in, then test the window
    logic                          full;
    sfmf_pkg::window_t             win_shift;
    logic [sfmf_pkg::CNT_W-1:0]    seen_inc;
    logic [sfmf_pkg::CNT_W-1:0]    seen_after;
    logic [sfmf_pkg::CNT_W-1:0]    start_pos;
    logic                          eq;
    logic                          hit;
    logic                          empty_ok;
    logic                          res_found;
    logic [sfmf_pkg::POS_W-1:0]    res_pos;

    // Bytes beyond MAX_SOURCE are dropped: neither stored nor counted
    assign full      = (seen_reg >= sfmf_pkg::CNT_W'(sfmf_pkg::MAX_SOURCE));
    assign win_shift = {in_byte_reg, win_reg[sfmf_pkg::MAX_PATTERN-1:1]};
    assign seen_inc  = seen_reg + sfmf_pkg::CNT_W'(1);
    assign seen_after = full ? seen_reg : seen_inc;
    assign start_pos = seen_inc - sfmf_pkg::CNT_W'(cfg.active_len);

    sfmf_match u_match (
        .window (win_shift),
        .cfg    (cfg),
        .equal  (eq)
    );

    assign hit = !full && (cfg.active_len != '0) && !match_seen_reg &&
                 (seen_inc >= sfmf_pkg::CNT_W'(cfg.active_len)) &&
                 (start_pos >= sfmf_pkg::CNT_W'(cfg.start_offset)) && eq;

    // Empty pattern matches at the offset if the offset is no greater than the source length
    assign empty_ok = (sfmf_pkg::CNT_W'(cfg.start_offset) <= seen_after);

    always_comb begin
        if (cfg.active_len == '0) begin
            res_found = empty_ok;
            res_pos   = empty_ok ? cfg.start_offset : '0;
        end else if (match_seen_reg) begin
            res_found = 1'b1;
            res_pos   = match_start_reg;
        end else if (hit) begin
            res_found = 1'b1;
            res_pos   = start_pos[sfmf_pkg::POS_W-1:0];
        end else begin
            res_found = 1'b0;
            res_pos   = '0;
        end
    end

    // Window holds payload only; stale bytes are never compared because a
    // compare needs at least active_len bytes of the current source.
    always_ff @(posedge aclk) begin
        if (advance && !full) begin
            win_reg <= win_shift;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg        <= '0;
            match_seen_reg  <= 1'b0;
            match_start_reg <= '0;
        end else if (advance) begin
            if (in_last_reg) begin
                seen_reg        <= '0;
                match_seen_reg  <= 1'b0;
                match_start_reg <= '0;
            end else begin
                seen_reg <= seen_after;
                if (hit) begin
                    match_seen_reg  <= 1'b1;
                    match_start_reg <= start_pos[sfmf_pkg::POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_found_reg <= res_found;
            out_pos_reg   <= res_pos;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_pos_reg;

    // A miss always reports position zero
    a_miss_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss reported with nonzero position");

    // Byte count never passes the source limit
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= sfmf_pkg::CNT_W'(sfmf_pkg::MAX_SOURCE))
        else $error("byte count beyond source limit");

    // Closing a source clears its state
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> seen_reg == '0 && !match_seen_reg)
        else $error("source state not cleared after last item");

    // Input stalls only while an item is held
    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && in_last_reg && out_valid_reg)
        else $error("input stalled without a blocked last item");

    // A recorded match starts inside the bytes counted so far
    a_match_in_source: assert property (@(posedge aclk) disable iff (!aresetn)
        match_seen_reg |-> sfmf_pkg::CNT_W'(match_start_reg) < seen_reg)
        else $error("match start outside the source");

endmodule

/* tb/sfmf_result_checker.sv */
// Result checker for the substring first-match finder: predicts each result and compares it.
module sfmf_result_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [15:0]                         m_tdata,
    input  logic                                m_tuser,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [sfmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfmf_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  mismatch_count,
    output int                                  results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                          found;
        logic [sfmf_pkg::POS_W-1:0]    position;
    } search_result_t;

    // configuration copy
    logic [63:0]                   pat_lo;
    logic [63:0]                   pat_hi;
    logic [4:0]                    pat_len;
    logic                          fold_on;
    logic [sfmf_pkg::POS_W-1:0]    min_start;

    // per-source state
    logic [7:0]                    history [sfmf_pkg::MAX_PATTERN];
    logic [sfmf_pkg::CNT_W-1:0]    count;
    logic                          hit;
    logic [sfmf_pkg::POS_W-1:0]    hit_pos;

    search_result_t    expected_results[$];
    search_result_t    got;
    search_result_t    want;

    function automatic logic [7:0] lower_letter(input logic [7:0] c);
        if (fold_on && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    task automatic clear_source();
        int k;
        for (k = 0; k < sfmf_pkg::MAX_PATTERN; k++) begin
            history[k] = '0;
        end
        count   = '0;
        hit     = 1'b0;
        hit_pos = '0;
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic last);
        int             span;
        int             start;
        int             k;
        bit             same;
        logic [127:0]   pat;
        search_result_t r;
        span = (pat_len > sfmf_pkg::MAX_PATTERN) ? sfmf_pkg::MAX_PATTERN : int'(pat_len);
        pat  = {pat_hi, pat_lo};
        // bytes past the source limit are dropped, but tlast still closes the source
        if (count < sfmf_pkg::MAX_SOURCE) begin
            for (k = 0; k < sfmf_pkg::MAX_PATTERN - 1; k++) begin
                history[k] = history[k + 1];
            end
            history[sfmf_pkg::MAX_PATTERN - 1] = b;
            count = count + 1'b1;
            if (span > 0 && !hit && int'(count) >= span) begin
                start = int'(count) - span;
                if (start >= int'(min_start)) begin
                    same = 1'b1;
                    for (k = 0; k < span; k++) begin
                        if (lower_letter(history[sfmf_pkg::MAX_PATTERN - span + k]) !=
                            lower_letter(pat[k*8 +: 8])) begin
                            same = 1'b0;
                        end
                    end
                    if (same) begin
                        hit     = 1'b1;
                        hit_pos = start[sfmf_pkg::POS_W-1:0];
                    end
                end
            end
        end
        if (last) begin
            if (span == 0) begin
                r.found    = (int'(min_start) <= int'(count));
                r.position = r.found ? min_start : '0;
            end else begin
                r.found    = hit;
                r.position = hit ? hit_pos : '0;
            end
            expected_results.push_back(r);
            clear_source();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo         = '0;
            pat_hi         = '0;
            pat_len        = '0;
            fold_on        = 1'b1;
            min_start      = '0;
            mismatch_count = 0;
            clear_source();
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sfmf_pkg::REG_PATTERN_LOW:  pat_lo    = cfg_data;
                    sfmf_pkg::REG_PATTERN_HIGH: pat_hi    = cfg_data;
                    sfmf_pkg::REG_PATTERN_LEN:  pat_len   = cfg_data[4:0];
                    sfmf_pkg::REG_CASE_INSENS:  fold_on   = cfg_data[0];
                    sfmf_pkg::REG_START_OFFSET: min_start = cfg_data[sfmf_pkg::POS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                scan_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                got.found    = m_tuser;
                got.position = m_tdata;
                if (expected_results.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("unexpected result: found=%0b position=%0d",
                                 m_tuser, m_tdata);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display({"result mismatch: expected found=%0b position=%0d,",
                                      " got found=%0b position=%0d"},
                                     want.found, want.position, got.found, got.position);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        results_due = expected_results.size();
    end

endmodule

/* tb/tb_substring_first_match_finder_unit.sv */
// Testbench top: drives source bytes and settings into the finder and reports the verdict.
module tb_substring_first_match_finder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // The cycle limit leaves ample room for the slowest correct run, even at heavy
    // idling and with the long receiver hold-off.
    localparam int LIMIT_CYCLES   = 100_000;
    localparam int DRAIN_CYCLES   = 6;      // drain margin after the last result
    localparam int LONG_HOLD      = 300;    // receiver hold-off for the pressure burst
    localparam int ROUNDS         = 8;
    localparam int ROUND_ITEMS    = 105;
    localparam int BURST_ITEMS    = 48;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [7:0]                          s_tdata;
    logic                                s_tlast;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [15:0]                         m_tdata;
    logic                                m_tuser;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [sfmf_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [sfmf_pkg::CFG_DATA_W-1:0]     cfg_data;

    int mismatch_count;
    int results_due;

    // idling controls, percent of cycles
    int src_idle      = 0;
    int sink_stall    = 0;
    int hold_requests = 0;
    int cycle_count   = 0;

    // current pattern as loaded, used to plant copies in the text
    logic [7:0] pat_bytes [sfmf_pkg::MAX_PATTERN];
    int         pat_use = 0;

    substring_first_match_finder_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sfmf_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver. Random stalls at the current rate; a new hold request from the
    // stimulus process starts a long hold-off counted down here.
    initial begin
        int holds_started;
        int hold_left;
        holds_started = 0;
        hold_left     = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_started != hold_requests) begin
                holds_started = hold_requests;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_stall);
            end
        end
    end

    // Text byte mix: pattern bytes, letters of either case, the characters either
    // side of A-Z and a-z (fold boundaries), and anything at all.
    function automatic logic [7:0] text_byte();
        int         pick;
        logic [7:0] letter;
        pick   = $urandom_range(0, 99);
        letter = 8'($urandom_range(0, 25));
        if (pick < 40 && pat_use > 0) begin
            return pat_bytes[$urandom_range(0, pat_use - 1)];
        end
        if (pick < 70) begin
            return $urandom_range(0, 1) ? 8'h41 + letter : 8'h61 + letter;
        end
        if (pick < 80) begin
            case ($urandom_range(0, 3))
                0:       return 8'h40;
                1:       return 8'h5B;
                2:       return 8'h60;
                default: return 8'h7B;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // One source item; returns at the edge where it is taken. tvalid stays high,
    // the next call or settle() decides what happens to it.
    task automatic send_item(input logic [7:0] b, input logic l);
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_string(input string str, input logic close);
        int i;
        for (i = 0; i < str.len(); i++) begin
            send_item(str[i], close && (i == str.len() - 1));
        end
    endtask

    task automatic write_reg(input logic [sfmf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
    endtask

    // Writes all five registers; noisy fills the unused upper data bits with
    // rubbish, spare also pokes the unassigned indexes, which must change nothing.
    task automatic load_settings(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [4:0] len, input logic ci,
                                 input logic [15:0] off, input bit noisy, input bit spare);
        logic [63:0] junk;
        int          k;
        junk = noisy ? {$urandom, $urandom} : 64'd0;
        write_reg(sfmf_pkg::REG_PATTERN_LOW, lo);
        write_reg(sfmf_pkg::REG_PATTERN_HIGH, hi);
        write_reg(sfmf_pkg::REG_PATTERN_LEN, {junk[63:5], len});
        write_reg(sfmf_pkg::REG_CASE_INSENS, {junk[63:1], ci});
        write_reg(sfmf_pkg::REG_START_OFFSET, {junk[63:16], off});
        if (spare) begin
            for (k = int'(sfmf_pkg::REG_START_OFFSET) + 1; k < 2 ** sfmf_pkg::CFG_IDX_W;
                 k++) begin
                write_reg(sfmf_pkg::CFG_IDX_W'(k), {$urandom, $urandom});
            end
        end
        cfg_valid <= 1'b0;
        for (k = 0; k < sfmf_pkg::MAX_PATTERN; k++) begin
            pat_bytes[k] = (k < 8) ? lo[k*8 +: 8] : hi[(k-8)*8 +: 8];
        end
        pat_use = (len > sfmf_pkg::MAX_PATTERN) ? sfmf_pkg::MAX_PATTERN : int'(len);
    endtask

    // Stop offering, wait for every expected result, then let the pipe empty
    // (a byte without tlast gives no result but may still be in flight).
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len5;
        logic        ci;
        logic [15:0] off;
        logic [7:0]  b;
        logic [7:0]  text [$];
        int          r;
        int          j;
        int          p;
        int          slen;
        int          sent;

        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn   <= 1'b1;

        // ---- directed part ----
        // reset settings: empty pattern at offset 0 matches straight away
        send_string("A", 1'b1);

        // empty pattern, offset 2: beyond a one-byte source, reached by two bytes
        settle();
        load_settings(64'd0, 64'd0, 5'd0, 1'b1, 16'd2, 1'b0, 1'b0);
        send_string("q", 1'b1);
        send_string("qr", 1'b1);

        // "Ab", folding on: "aB" at 1 counts
        settle();
        load_settings(64'h6241, 64'd0, 5'd2, 1'b1, 16'd0, 1'b0, 1'b0);
        send_string("xaB", 1'b1);

        // same pattern, folding off: only the exact "Ab" at 2
        settle();
        load_settings(64'h6241, 64'd0, 5'd2, 1'b0, 16'd0, 1'b0, 1'b0);
        send_string("aBAb", 1'b1);

        // full 16-byte pattern with 00 and FF, length written as 20 (clamped)
        settle();
        lo        = {$urandom, $urandom};
        lo[7:0]   = 8'h00;
        lo[15:8]  = 8'hFF;
        hi        = {$urandom, $urandom};
        load_settings(lo, hi, 5'd20, 1'b1, 16'd0, 1'b1, 1'b1);
        for (j = 0; j < sfmf_pkg::MAX_PATTERN; j++) begin
            send_item(pat_bytes[j], j == sfmf_pkg::MAX_PATTERN - 1);
        end

        // settings changed mid-source: the match already held survives
        settle();
        load_settings(64'h6261, 64'd0, 5'd2, 1'b0, 16'd0, 1'b0, 1'b0);
        send_string("ab", 1'b0);
        settle();
        load_settings(64'h6261, 64'd0, 5'd2, 1'b0, 16'd100, 1'b0, 1'b0);
        send_string("a", 1'b1);

        // ---- pressure: long receiver hold-off, sender keeps offering short sources ----
        settle();
        load_settings(64'h6261, 64'd0, 5'd2, 1'b1, 16'd0, 1'b0, 1'b0);
        hold_requests++;
        for (j = 0; j < BURST_ITEMS; j++) begin
            send_item(text_byte(), (j == BURST_ITEMS - 1) || ($urandom_range(0, 2) == 0));
        end

        // ---- random rounds, one setting each, idling mode cycling ----
        for (r = 0; r < ROUNDS; r++) begin
            settle();
            case (r % 4)
                0:       begin src_idle = 0;  sink_stall = 0;  end
                1:       begin src_idle = 84; sink_stall = 0;  end
                2:       begin src_idle = 0;  sink_stall = 84; end
                default: begin src_idle = 30; sink_stall = 30; end
            endcase

            len5 = 5'($urandom_range(1, 12));
            ci   = 1'($urandom_range(0, 1));
            off  = 16'($urandom_range(0, 3));
            for (j = 0; j < 8; j++) begin
                lo[j*8 +: 8] = text_byte();
                hi[j*8 +: 8] = text_byte();
            end
            // extremes spread over the rounds
            case (r)
                0: begin ci = 1'b1; len5 = 5'($urandom_range(1, 4)); end
                1: len5 = 5'd0;
                2: begin len5 = 5'd16; ci = 1'b0; end
                3: off = 16'hFFFF;
                4: off = 16'($urandom_range(0, 65535));
                5: len5 = 5'd31;
                6: off = 16'($urandom_range(4, 20));
                7: begin
                    lo   = {$urandom, $urandom};
                    hi   = {$urandom, $urandom};
                    len5 = 5'($urandom_range(17, 30));
                end
                default: ;
            endcase
            load_settings(lo, hi, len5, ci, off, r[0], (r % 3) == 0);

            sent = 0;
            while (sent < ROUND_ITEMS) begin
                text.delete();
                slen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                   : $urandom_range(1, 20);
                for (j = 0; j < slen; j++) begin
                    text.push_back(text_byte());
                end
                // most sources carry a copy of the pattern, case shuffled when
                // folding is on; now and then the copy is spoilt at its tail
                if (pat_use > 0 && pat_use <= slen && $urandom_range(0, 9) < 6) begin
                    p = $urandom_range(0, slen - pat_use);
                    for (j = 0; j < pat_use; j++) begin
                        b = pat_bytes[j];
                        if (ci && (b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A &&
                            $urandom_range(0, 1)) begin
                            b = b ^ 8'h20;
                        end
                        text[p + j] = b;
                    end
                    if ($urandom_range(0, 4) == 0) begin
                        text[p + pat_use - 1] = text[p + pat_use - 1] ^ 8'h01;
                    end
                end
                for (j = 0; j < slen; j++) begin
                    send_item(text[j], j == slen - 1);
                end
                sent += slen;
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
